// File: hdl/clnws_pkg.sv
// Shared types and constants for the character LCD nibble write sequencer.
// Used by clnws_ctrl, clnws_dp and the top level; depends on nothing else.
package clnws_pkg;

  localparam int unsigned HoldBitsDefault = 22;

  // Widths of the fixed fields and registers.
  localparam int unsigned PulseW  = 16;
  localparam int unsigned WaitW   = 22;
  localparam int unsigned SumW    = 23;
  localparam int unsigned KindW   = 3;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgIdxW = 3;

  // Input word layout, lowest bit first: kind, value, row, column.
  localparam int unsigned InDataW = 24;

  // Register reset values.
  localparam logic [PulseW-1:0] PulseReset      = 16'd36;
  localparam logic [WaitW-1:0]  CmdSetupReset   = 22'd3200;
  localparam logic [WaitW-1:0]  CmdSettleReset  = 22'd400000;
  localparam logic [WaitW-1:0]  DataSetupReset  = 22'd4000;
  localparam logic [WaitW-1:0]  DataMidReset    = 22'd16000;
  localparam logic [WaitW-1:0]  DataEndReset    = 22'd96000;

  // Fixed power-on waits.
  localparam logic [SumW-1:0]   PowerWait = 23'd3200000;
  localparam logic [WaitW-1:0]  FirstWait = 22'd328000;
  localparam logic [WaitW-1:0]  ShortWait = 22'd12000;

  typedef enum logic [KindW-1:0] {
    KIND_INIT  = 3'd0,
    KIND_CMD   = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_GOTO  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE      = 3'd0,
    REG_CMD_SETUP  = 3'd1,
    REG_CMD_SETTLE = 3'd2,
    REG_DATA_SETUP = 3'd3,
    REG_DATA_MID   = 3'd4,
    REG_DATA_END   = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    SEG_POWER,
    SEG_INIT_EN,
    SEG_INIT_WAIT,
    SEG_SETUP,
    SEG_HI_EN,
    SEG_HI_WAIT,
    SEG_LO_EN,
    SEG_LO_WAIT
  } seg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POWER,
    ST_INIT_EN,
    ST_INIT_WAIT,
    ST_SETUP,
    ST_HI_EN,
    ST_HI_WAIT,
    ST_LO_EN,
    ST_LO_WAIT
  } state_e;

  typedef struct packed {
    logic            load;
    logic            issue;
    seg_e            seg;
    logic [IdxW-1:0] idx;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: hdl/clnws_ctrl.sv
// Controller state machine: walks the segment program of one request.
// Depends on clnws_pkg; drives clnws_dp through dp_cmd_t.
module clnws_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic [clnws_pkg::KindW-1:0]     req_kind_i,
  output logic                            req_ready_o,
  input  clnws_pkg::dp_status_t           status_i,
  output clnws_pkg::dp_cmd_t              cmd_o
);
  import clnws_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  kind_e           kind_q, kind_d;
  logic [IdxW-1:0] last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      kind_q  <= KIND_INIT;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      kind_q  <= kind_d;
    end
  end

  // Index of the final byte of the request in progress.
  always_comb begin
    unique case (kind_q)
      KIND_INIT:  last_byte = IdxW'(4);
      KIND_CLEAR: last_byte = IdxW'(1);
      default:    last_byte = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    req_ready_o = (state_q == ST_IDLE);
    cmd_o       = '0;
    cmd_o.idx   = idx_q;

    unique case (state_q)
      ST_POWER:     cmd_o.seg = SEG_POWER;
      ST_INIT_EN:   cmd_o.seg = SEG_INIT_EN;
      ST_INIT_WAIT: cmd_o.seg = SEG_INIT_WAIT;
      ST_SETUP:     cmd_o.seg = SEG_SETUP;
      ST_HI_EN:     cmd_o.seg = SEG_HI_EN;
      ST_HI_WAIT:   cmd_o.seg = SEG_HI_WAIT;
      ST_LO_EN:     cmd_o.seg = SEG_LO_EN;
      ST_LO_WAIT:   cmd_o.seg = SEG_LO_WAIT;
      default:      cmd_o.seg = SEG_POWER;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        // Unknown kinds are taken and dropped without any segment.
        if (req_valid_i && (req_kind_i <= KIND_CLEAR)) begin
          kind_d     = kind_e'(req_kind_i);
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = (kind_e'(req_kind_i) == KIND_INIT) ? ST_POWER : ST_SETUP;
        end
      end
      default: begin
        if (status_i.out_free) begin
          cmd_o.issue = 1'b1;
          unique case (state_q)
            ST_POWER:   state_d = ST_INIT_EN;
            ST_INIT_EN: state_d = ST_INIT_WAIT;
            ST_INIT_WAIT: begin
              if (idx_q == IdxW'(3)) begin
                idx_d   = '0;
                state_d = ST_SETUP;
              end else begin
                idx_d   = idx_q + IdxW'(1);
                state_d = ST_INIT_EN;
              end
            end
            ST_SETUP:   state_d = ST_HI_EN;
            ST_HI_EN:   state_d = ST_HI_WAIT;
            ST_HI_WAIT: state_d = ST_LO_EN;
            ST_LO_EN:   state_d = ST_LO_WAIT;
            ST_LO_WAIT: begin
              if (idx_q == last_byte) begin
                cmd_o.last = 1'b1;
                state_d    = ST_IDLE;
              end else begin
                idx_d   = idx_q + IdxW'(1);
                state_d = ST_SETUP;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

endmodule

// File: hdl/clnws_dp.sv
// Datapath: timing registers, request latch, segment builder and output register.
// Depends on clnws_pkg; commanded by clnws_ctrl.
module clnws_dp #(
  parameter int unsigned HOLD_BITS = clnws_pkg::HoldBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [clnws_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [clnws_pkg::WaitW-1:0]       cfg_data_i,
  input  logic [clnws_pkg::InDataW-1:0]     req_data_i,
  input  clnws_pkg::dp_cmd_t                cmd_i,
  output clnws_pkg::dp_status_t             status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_rs_o,
  output logic                              out_en_o,
  output logic [3:0]                        out_nibble_o,
  output logic [HOLD_BITS-1:0]              out_hold_o,
  output logic                              out_last_o
);
  import clnws_pkg::*;

  localparam logic [32:0] HoldMax = (33'd1 << HOLD_BITS) - 33'd1;

  logic [PulseW-1:0] pulse_q;
  logic [WaitW-1:0]  cmd_setup_q, cmd_settle_q, data_setup_q, data_mid_q, data_end_q;

  kind_e       kind_q;
  logic [7:0]  value_q;
  logic        row_q;
  logic [5:0]  column_q;
  logic [3:0]  held_nibble_q, held_nibble_d;

  logic             valid_q;
  logic             rs_q, en_q, last_q;
  logic [3:0]       nib_q;
  logic [HOLD_BITS-1:0] hold_q;

  logic             seg_rs, seg_en;
  logic [3:0]       seg_nib, init_nib;
  logic [7:0]       cur_byte;
  logic [WaitW-1:0] init_wait;
  logic [SumW-1:0]  seg_sum;
  logic [32:0]      sum_ext;
  logic [HOLD_BITS-1:0] seg_hold;

  assign status_o.out_free = !valid_q || out_ready_i;

  // Timing registers; writes to an index past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q      <= PulseReset;
      cmd_setup_q  <= CmdSetupReset;
      cmd_settle_q <= CmdSettleReset;
      data_setup_q <= DataSetupReset;
      data_mid_q   <= DataMidReset;
      data_end_q   <= DataEndReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PULSE:      pulse_q      <= cfg_data_i[PulseW-1:0];
        REG_CMD_SETUP:  cmd_setup_q  <= cfg_data_i;
        REG_CMD_SETTLE: cmd_settle_q <= cfg_data_i;
        REG_DATA_SETUP: data_setup_q <= cfg_data_i;
        REG_DATA_MID:   data_mid_q   <= cfg_data_i;
        REG_DATA_END:   data_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_e'(req_data_i[2:0]);
      value_q  <= req_data_i[10:3];
      row_q    <= req_data_i[11];
      column_q <= req_data_i[17:12];
    end
  end

  // Byte sent for the current byte slot of the request.
  always_comb begin
    unique case (kind_q)
      KIND_INIT: begin
        unique case (cmd_i.idx)
          IdxW'(0): cur_byte = 8'h28;
          IdxW'(1): cur_byte = 8'h08;
          IdxW'(2): cur_byte = 8'h0F;
          IdxW'(3): cur_byte = 8'h01;
          default:  cur_byte = 8'h06;
        endcase
      end
      KIND_CLEAR: cur_byte = (cmd_i.idx == '0) ? 8'h01 : 8'h02;
      KIND_GOTO:  cur_byte = (row_q ? 8'hC0 : 8'h80) + {2'b00, column_q};
      default:    cur_byte = value_q;
    endcase
  end

  assign init_nib  = (cmd_i.idx == IdxW'(3)) ? 4'h2 : 4'h3;
  assign init_wait = (cmd_i.idx == '0) ? FirstWait : ShortWait;

  always_comb begin
    seg_rs        = (kind_q == KIND_DATA);
    seg_en        = 1'b0;
    seg_nib       = held_nibble_q;
    seg_sum       = {7'd0, pulse_q};
    held_nibble_d = held_nibble_q;
    unique case (cmd_i.seg)
      SEG_POWER: begin
        seg_rs        = 1'b0;
        seg_nib       = 4'h0;
        seg_sum       = PowerWait;
        held_nibble_d = 4'h0;
      end
      SEG_INIT_EN: begin
        seg_rs        = 1'b0;
        seg_en        = 1'b1;
        seg_nib       = init_nib;
        held_nibble_d = init_nib;
      end
      SEG_INIT_WAIT: begin
        seg_rs  = 1'b0;
        seg_nib = init_nib;
        seg_sum = {7'd0, pulse_q} + {1'b0, init_wait};
      end
      SEG_SETUP: begin
        seg_sum = {1'b0, seg_rs ? data_setup_q : cmd_setup_q};
      end
      SEG_HI_EN: begin
        seg_en        = 1'b1;
        seg_nib       = cur_byte[7:4];
        held_nibble_d = cur_byte[7:4];
      end
      SEG_HI_WAIT: begin
        seg_nib = cur_byte[7:4];
        seg_sum = {7'd0, pulse_q} + {1'b0, seg_rs ? data_mid_q : cmd_settle_q};
      end
      SEG_LO_EN: begin
        seg_en        = 1'b1;
        seg_nib       = cur_byte[3:0];
        held_nibble_d = cur_byte[3:0];
      end
      SEG_LO_WAIT: begin
        seg_nib = cur_byte[3:0];
        seg_sum = {7'd0, pulse_q} + {1'b0, seg_rs ? data_end_q : cmd_settle_q};
      end
      default: ;
    endcase
  end

  // Holds beyond the output width saturate.
  always_comb begin
    sum_ext  = 33'(seg_sum);
    seg_hold = (sum_ext > HoldMax) ? HoldMax[HOLD_BITS-1:0] : sum_ext[HOLD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      held_nibble_q <= 4'h0;
    end else begin
      if (cmd_i.issue) begin
        valid_q       <= 1'b1;
        held_nibble_q <= held_nibble_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rs_q   <= seg_rs;
      en_q   <= seg_en;
      nib_q  <= seg_nib;
      hold_q <= seg_hold;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_rs_o     = rs_q;
  assign out_en_o     = en_q;
  assign out_nibble_o = nib_q;
  assign out_hold_o   = hold_q;
  assign out_last_o   = last_q;

endmodule

// File: hdl/char_lcd_nibble_write_sequencer_unit.sv
// Top level of the character LCD nibble write sequencer.
// Instantiates clnws_ctrl and clnws_dp; types and constants from clnws_pkg.
//
// Usage: each word on the slave stream is one request for a 4-bit character
// LCD: power-on init, command byte, data byte, cursor goto or clear screen.
// The block answers with a run of pin segments on the master stream, one
// word per segment, giving RS, EN, the bus nibble and a hold time in clocks;
// tlast marks the final segment of the request. A byte becomes five segments
// (setup, then EN high and EN low for each nibble, high nibble first), a
// clear ten and the init sequence thirty-four.
// Timing: a request is taken only while the controller is idle. The request is
// registered into the controller state and the request latch, and each segment
// then passes through the output register; while the receiver is ready,
// segments follow one per cycle, as the controller's segment walk issues them.
// Requests of an unknown kind are taken and give no segments.
// The timing registers are written through the cfg channel, which is always
// ready, and should only be changed while no request is in flight.
// Reset restores the register defaults, clears the held bus nibble and
// empties the output register. When the receiver stalls, the pending segment
// holds in the output register and the walk pauses until it is taken.
module char_lcd_nibble_write_sequencer_unit #(
  parameter int unsigned HOLD_BITS = clnws_pkg::HoldBitsDefault,
  localparam int unsigned OutDataW = ((6 + HOLD_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request words. tdata fields from bit 0: kind[2:0], value[10:3],
  // row[11], column[17:12], zero fill above.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [clnws_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Segment words. tdata fields from bit 0: rs_level[0], enable_level[1],
  // bus_nibble[5:2], hold_cycles[HOLD_BITS+5:6], zero fill above.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [OutDataW-1:0]             m_axis_tdata_o,
  output logic                            m_axis_tlast_o,
  // Register writes: index selects the timing register, data is its value.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [clnws_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [clnws_pkg::WaitW-1:0]     cfg_data_i
);
  import clnws_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic                 out_rs, out_en;
  logic [3:0]           out_nib;
  logic [HOLD_BITS-1:0] out_hold;

  assign cfg_ready_o = 1'b1;

  clnws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_kind_i  (s_axis_tdata_i[KindW-1:0]),
    .req_ready_o (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clnws_dp #(
    .HOLD_BITS (HOLD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_data_i   (s_axis_tdata_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_rs_o     (out_rs),
    .out_en_o     (out_en),
    .out_nibble_o (out_nib),
    .out_hold_o   (out_hold),
    .out_last_o   (m_axis_tlast_o)
  );

  // Segment fields packed from the lowest bit, zero filled to whole bytes.
  assign m_axis_tdata_o = OutDataW'({out_hold, out_nib, out_en, out_rs});

endmodule
